### rtl/mtacc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtacc_pkg
// Shared constants, types and helpers of the 4x4 matrix tile accumulator.
// ----------------------------------------------------------------------------
package mtacc_pkg;

  // tile geometry
  localparam int TILE        = 4;
  localparam int NUM_CELLS   = TILE * TILE;
  localparam int IDX_WIDTH   = $clog2(NUM_CELLS);
  localparam int CNT_WIDTH   = $clog2(NUM_CELLS + 1);
  localparam int COORD_WIDTH = $clog2(TILE);

  // operand, accumulator and output widths
  localparam int OPER_WIDTH = 32;
  localparam int SUM_WIDTH  = 32;
  localparam int DATA_WIDTH = 32;
  localparam int WIDE_WIDTH = 64;

  localparam logic [IDX_WIDTH-1:0] LAST_IDX = IDX_WIDTH'(NUM_CELLS - 1);
  localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(NUM_CELLS);
  localparam logic [COORD_WIDTH-1:0] LAST_COORD = COORD_WIDTH'(TILE - 1);

  typedef logic signed [OPER_WIDTH-1:0] oper_t;
  typedef logic [DATA_WIDTH-1:0]        acc_t;
  typedef logic signed [SUM_WIDTH-1:0]  sum_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic mul_en;   // capture a new product
    logic acc_en;   // fold the product into the accumulator
    logic last;     // product belongs to the final inner step
    logic load;     // copy finished sum into the drain register
    logic shift;    // drain chain moves one place toward the output
  } cell_ctrl_t;

  // sign-extend the operand, keep the accumulator width
  function automatic acc_t to_acc(input oper_t v);
    logic [WIDE_WIDTH-1:0] w;
    begin
      w = {{(WIDE_WIDTH - OPER_WIDTH){v[OPER_WIDTH-1]}}, v};
      return w[DATA_WIDTH-1:0];
    end
  endfunction

  // low output bits of the accumulator, zero filled when narrower
  function automatic sum_t to_sum(input acc_t v);
    logic [WIDE_WIDTH-1:0] w;
    begin
      w = {{(WIDE_WIDTH - DATA_WIDTH){1'b0}}, v};
      return w[SUM_WIDTH-1:0];
    end
  endfunction

endpackage

### rtl/mtacc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtacc_if
// Valid/ready channels of the tile accumulator: operand steps in, sums out.
// ----------------------------------------------------------------------------
interface mtacc_in_if;
  import mtacc_pkg::*;
  logic  valid;
  logic  ready;
  oper_t a_row0;
  oper_t a_row1;
  oper_t a_row2;
  oper_t a_row3;
  oper_t b_col0;
  oper_t b_col1;
  oper_t b_col2;
  oper_t b_col3;
  logic  last_step;

  modport source (output valid, a_row0, a_row1, a_row2, a_row3,
                  b_col0, b_col1, b_col2, b_col3, last_step, input ready);
  modport sink   (input valid, a_row0, a_row1, a_row2, a_row3,
                  b_col0, b_col1, b_col2, b_col3, last_step, output ready);
endinterface

interface mtacc_out_if;
  import mtacc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] tile_row;
  logic [COORD_WIDTH-1:0] tile_col;
  sum_t                   sum_value;
  logic                   tile_done;

  modport source (output valid, tile_row, tile_col, sum_value, tile_done,
                  input ready);
  modport sink   (input valid, tile_row, tile_col, sum_value, tile_done,
                  output ready);
endinterface

### rtl/matmul_tile_4x4_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matmul_tile_4x4_accumulator
// 4x4 matrix product tile: sixteen multiply-accumulate cells, drained in
// row-major order through a shift chain that runs across the cells.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                       | request
//  --------+-----+-----------------------------------------------+----------------
//  in_i    | in  | a_row0..3, b_col0..3, last_step               | one inner step
//  out_o   | out | tile_row, tile_col, sum_value, tile_done      | one tile element
//
//  Takes one inner step per cycle while not stalled; products are registered at
//  the accepting edge and folded into the accumulators from that register.
//  A step marked last loads all sixteen sums into the drain chain as it leaves
//  the product stage; the first result can be taken once the chain is loaded,
//  then one result per cycle while ready, as the next tile keeps accumulating.
//  Input stalls while a last step waits in the product stage and the previous
//  tile still has more than one result to deliver, or its final result is not
//  taken in that cycle; tiles shorter than sixteen steps run at the drain rate.
//  Reset clears accumulators, valid flags and the drain count.
// ----------------------------------------------------------------------------
module matmul_tile_4x4_accumulator
  import mtacc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  mtacc_in_if.sink     in_i,
  mtacc_out_if.source  out_o
);

  acc_t a_ops [TILE];
  acc_t b_ops [TILE];
  acc_t chain [NUM_CELLS+1];

  logic                 v1_q;
  logic                 last1_q;
  logic [CNT_WIDTH-1:0] cnt_q;
  logic [IDX_WIDTH-1:0] idx_q;
  logic                 pop;
  logic                 drain_free;
  logic                 stall;
  logic                 accept;
  cell_ctrl_t           ctrl;

  // operands at accumulator width
  assign a_ops[0] = to_acc(in_i.a_row0);
  assign a_ops[1] = to_acc(in_i.a_row1);
  assign a_ops[2] = to_acc(in_i.a_row2);
  assign a_ops[3] = to_acc(in_i.a_row3);
  assign b_ops[0] = to_acc(in_i.b_col0);
  assign b_ops[1] = to_acc(in_i.b_col1);
  assign b_ops[2] = to_acc(in_i.b_col2);
  assign b_ops[3] = to_acc(in_i.b_col3);

  // handshake and stall
  assign pop        = out_o.valid & out_o.ready;
  assign drain_free = (cnt_q == '0) | ((cnt_q == CNT_WIDTH'(1)) & out_o.ready);
  assign stall      = v1_q & last1_q & ~drain_free;
  assign in_i.ready = ~stall;
  assign accept     = in_i.valid & ~stall;

  // product stage flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      last1_q <= 1'b0;
    end else if (!stall) begin
      v1_q    <= accept;
      last1_q <= accept & in_i.last_step;
    end
  end

  // cell control
  always_comb begin
    ctrl.mul_en = accept;
    ctrl.acc_en = v1_q & ~stall;
    ctrl.last   = last1_q;
    ctrl.load   = v1_q & last1_q & ~stall;
    ctrl.shift  = pop;
  end

  // drain count and element index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (ctrl.load) begin
      cnt_q <= FULL_CNT;
      idx_q <= '0;
    end else if (pop) begin
      cnt_q <= cnt_q - CNT_WIDTH'(1);
      idx_q <= idx_q + IDX_WIDTH'(1);
    end
  end

  // row of cells, drain chain ends at cell zero
  assign chain[NUM_CELLS] = '0;

  for (genvar gi = 0; gi < TILE; gi++) begin : g_row
    for (genvar gj = 0; gj < TILE; gj++) begin : g_col
      mtacc_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .a_i     (a_ops[gi]),
        .b_i     (b_ops[gj]),
        .shift_i (chain[gi*TILE+gj+1]),
        .shift_o (chain[gi*TILE+gj])
      );
    end
  end

  // result
  assign out_o.valid     = (cnt_q != '0);
  assign out_o.tile_row  = idx_q[IDX_WIDTH-1:COORD_WIDTH];
  assign out_o.tile_col  = idx_q[COORD_WIDTH-1:0];
  assign out_o.sum_value = to_sum(chain[0]);
  assign out_o.tile_done = (idx_q == LAST_IDX);

endmodule

### rtl/mtacc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtacc_cell
// One tile element: multiplier, accumulator and one place of the drain chain.
// ----------------------------------------------------------------------------
module mtacc_cell
  import mtacc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  acc_t       a_i,
  input  acc_t       b_i,
  input  acc_t       shift_i,
  output acc_t       shift_o
);

  acc_t prod_w;
  acc_t prod_q;
  acc_t acc_q;
  acc_t hold_q;
  acc_t sum_w;

  // product, wrapped to the accumulator width
  assign prod_w = a_i * b_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_w;
    end
  end

  assign sum_w = acc_q + prod_q;

  // running sum, cleared once the tile is handed to the drain chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= ctrl_i.last ? '0 : sum_w;
    end
  end

  // drain register: parallel load of the finished sum, then shift
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      hold_q <= sum_w;
    end else if (ctrl_i.shift) begin
      hold_q <= shift_i;
    end
  end

  assign shift_o = hold_q;

endmodule

### rtl/mtacc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtacc_checker
// Port-level checks on the result stream of the tile accumulator.
// ----------------------------------------------------------------------------
module mtacc_checker
  import mtacc_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [COORD_WIDTH-1:0] tile_row_i,
  input logic [COORD_WIDTH-1:0] tile_col_i,
  input sum_t                   sum_value_i,
  input logic                   tile_done_i
);

  // tile done only on the bottom-right element
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && tile_done_i |-> tile_row_i == LAST_COORD && tile_col_i == LAST_COORD)
    else $error("tile_done away from last element");

  // a tile drains without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !tile_done_i |=> out_valid_i)
    else $error("gap inside a tile");

  // elements leave in row-major order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !tile_done_i |=>
      {tile_row_i, tile_col_i} == $past({tile_row_i, tile_col_i}) + IDX_WIDTH'(1))
    else $error("element order broken");

  // stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(sum_value_i))
    else $error("stalled sum changed");

endmodule

bind matmul_tile_4x4_accumulator mtacc_checker u_mtacc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .tile_row_i  (out_o.tile_row),
  .tile_col_i  (out_o.tile_col),
  .sum_value_i (out_o.sum_value),
  .tile_done_i (out_o.tile_done)
);

### sim/tb_matmul_tile_4x4_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matmul_tile_4x4_accumulator
// Self-checking bench for the 4x4 tile accumulator. Operand steps go in over
// the input channel with random gaps. A local model keeps sixteen wrapping
// sums and queues the row-major tile expected for each step marked last.
// Every result taken off the output channel is matched against that queue.
// The output side stalls at random, and once for a long stretch.
// ----------------------------------------------------------------------------
module tb_matmul_tile_4x4_accumulator;
  import mtacc_pkg::*;

  localparam int  CLK_HALF_NS  = 10;
  localparam int  RESET_CYCLES = 12;
  localparam int  SETTLE_CYCLES = 24;
  localparam int  MAX_REPORTS  = 10;
  localparam int  LONG_HOLD    = 400;
  localparam real TIMEOUT_NS   = 10_000_000.0;

  // one inner step of operands
  typedef struct packed {
    logic                  last;
    oper_t [TILE-1:0]      b_op;
    oper_t [TILE-1:0]      a_op;
  } step_t;

  // one element of a finished tile
  typedef struct packed {
    logic [COORD_WIDTH-1:0] row;
    logic [COORD_WIDTH-1:0] col;
    sum_t                   sum;
    logic                   done;
  } tile_elem_t;

  logic clk_i;
  logic rst_ni;

  mtacc_in_if  in_if ();
  mtacc_out_if out_if ();

  matmul_tile_4x4_accumulator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // running sums of the tile in progress and tiles still owed
  acc_t       tile_sums [NUM_CELLS];
  tile_elem_t pending_elems [$];

  int err_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  // clock
  always begin
    clk_i = 1'b0;
    #CLK_HALF_NS;
    clk_i = 1'b1;
    #CLK_HALF_NS;
  end

  // fold one step into the sums, queue the tile when the step closes it
  function automatic void accumulate_step(input step_t s);
    tile_elem_t e;
    int k;
    for (int i = 0; i < TILE; i++) begin
      for (int j = 0; j < TILE; j++) begin
        k = i * TILE + j;
        tile_sums[k] = tile_sums[k] + acc_t'(s.a_op[i] * s.b_op[j]);
      end
    end
    if (s.last) begin
      for (int n = 0; n < NUM_CELLS; n++) begin
        e.row  = COORD_WIDTH'(n / TILE);
        e.col  = COORD_WIDTH'(n % TILE);
        e.sum  = sum_t'(tile_sums[n]);
        e.done = (n == NUM_CELLS - 1);
        pending_elems.push_back(e);
        tile_sums[n] = '0;
      end
    end
  endfunction

  // compare one delivered element with the oldest one owed
  function automatic void check_elem();
    tile_elem_t want;
    if (pending_elems.size() == 0) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("[%0t] unexpected result row=%0d col=%0d sum=%0d done=%0b", $realtime,
                 out_if.tile_row, out_if.tile_col, out_if.sum_value, out_if.tile_done);
    end else begin
      want = pending_elems.pop_front();
      if (out_if.tile_row !== want.row || out_if.tile_col !== want.col ||
          out_if.sum_value !== want.sum || out_if.tile_done !== want.done) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display({"[%0t] mismatch exp row=%0d col=%0d sum=%0d done=%0b",
                    " / got row=%0d col=%0d sum=%0d done=%0b"},
                   $realtime, want.row, want.col, want.sum, want.done,
                   out_if.tile_row, out_if.tile_col, out_if.sum_value, out_if.tile_done);
      end
    end
  endfunction

  // both channels are observed at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        accumulate_step({in_if.last_step,
                         in_if.b_col3, in_if.b_col2, in_if.b_col1, in_if.b_col0,
                         in_if.a_row3, in_if.a_row2, in_if.a_row1, in_if.a_row0});
      if (out_if.valid && out_if.ready)
        check_elem();
    end
  end

  // output side: long hold-off when requested, random stalls otherwise
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // drive one request and wait for it to be taken
  task automatic send_step(input step_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid     <= 1'b1;
    in_if.a_row0    <= s.a_op[0];
    in_if.a_row1    <= s.a_op[1];
    in_if.a_row2    <= s.a_op[2];
    in_if.a_row3    <= s.a_op[3];
    in_if.b_col0    <= s.b_op[0];
    in_if.b_col1    <= s.b_op[1];
    in_if.b_col2    <= s.b_op[2];
    in_if.b_col3    <= s.b_op[3];
    in_if.last_step <= s.last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // stop sending and let every owed result come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic step_t uniform_step(input oper_t a, input oper_t b, input logic last);
    step_t s;
    for (int i = 0; i < TILE; i++) begin
      s.a_op[i] = a;
      s.b_op[i] = b;
    end
    s.last = last;
    return s;
  endfunction

  // operand mix: extremes, small values and full-range values
  function automatic oper_t rand_oper();
    oper_t v;
    case ($urandom_range(9))
      0:       v = 32'h7fff_ffff;
      1:       v = 32'h8000_0000;
      2:       v = '0;
      3:       v = '1;
      4:       v = oper_t'($urandom_range(15)) - 8;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic step_t rand_step(input logic last);
    step_t s;
    for (int i = 0; i < TILE; i++) begin
      s.a_op[i] = rand_oper();
      s.b_op[i] = rand_oper();
    end
    s.last = last;
    return s;
  endfunction

  // extremes, wrap-around, single-step and multi-step tiles
  task automatic test_directed();
    step_t s;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_step(uniform_step('0, '0, 1'b1));
    send_step(uniform_step(32'h7fff_ffff, 32'h7fff_ffff, 1'b1));
    send_step(uniform_step(32'h8000_0000, 32'h8000_0000, 1'b1));
    send_step(uniform_step(32'h8000_0000, '1, 1'b1));
    send_step(uniform_step(32'h5555_5555, 32'haaaa_aaaa, 1'b1));
    s.a_op = {oper_t'('1), oper_t'('0), oper_t'(32'h8000_0000), oper_t'(32'h7fff_ffff)};
    s.b_op = {oper_t'('1), oper_t'(1), oper_t'(32'h8000_0000), oper_t'(32'h7fff_ffff)};
    s.last = 1'b1;
    send_step(s);
    // sums that overflow over several steps
    for (int k = 0; k < 4; k++)
      send_step(uniform_step(32'h7fff_ffff, 32'h7fff_ffff, k == 3));
    for (int k = 0; k < 3; k++)
      send_step(uniform_step(32'h7fff_ffff, oper_t'(1), k == 2));
    // ramp over eight steps
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < TILE; i++) begin
        s.a_op[i] = oper_t'(k * 4 + i - 13);
        s.b_op[i] = oper_t'(i * 1000 - k * 77);
      end
      s.last = (k == 7);
      send_step(s);
    end
    wait_drained();
  endtask

  // random tiles, mostly short with a few long ones
  task automatic test_random_tiles(input int n_steps, input int idle_pct, input int stall_pct);
    int sent;
    int len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_steps) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
      for (int k = 0; k < len; k++)
        send_step(rand_step(k == len - 1));
      sent += len;
    end
    wait_drained();
  endtask

  // output held off for a long stretch while short tiles keep coming
  task automatic test_long_hold();
    int len;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = LONG_HOLD;
    for (int t = 0; t < 8; t++) begin
      len = $urandom_range(3, 1);
      for (int k = 0; k < len; k++)
        send_step(rand_step(k == len - 1));
    end
    wait_drained();
  endtask

  // sender pauses until the previous tile is fully out
  task automatic test_pause_between_tiles();
    send_idle_pct  = 0;
    recv_stall_pct = 50;
    for (int t = 0; t < 3; t++) begin
      send_step(rand_step(1'b0));
      send_step(rand_step(1'b1));
      wait_drained();
    end
  endtask

  initial begin
    err_count       = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_left       = 0;
    foreach (tile_sums[n]) tile_sums[n] = '0;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.a_row0    = '0;
    in_if.a_row1    = '0;
    in_if.a_row2    = '0;
    in_if.a_row3    = '0;
    in_if.b_col0    = '0;
    in_if.b_col1    = '0;
    in_if.b_col2    = '0;
    in_if.b_col3    = '0;
    in_if.last_step = 1'b0;
    out_if.ready    = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_tiles(120, 29, 81);
    test_random_tiles(120, 81, 29);
    test_random_tiles(120, 0, 0);
    test_long_hold();
    test_pause_between_tiles();

    err_count += pending_elems.size();
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #TIMEOUT_NS;
    $display("Verification failed");
    $finish;
  end

endmodule
